[hdl/vifc_pkg.sv]
// Shared constants, register codes and types of the voxel interface face counter.
package vifc_pkg;

  // Default structural parameters.
  localparam int MAX_DIM_DEF    = 256;
  localparam int LABEL_BITS_DEF = 8;

  // Fixed field widths.
  localparam int FACE_W     = 26;
  localparam int CELL_W     = 25;
  localparam int PHASE_W    = 8;
  localparam int SIZE_W     = 9;
  localparam int PAD_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Saturation limits of the accumulators.
  localparam logic [FACE_W-1:0] FACE_MAX = '1;
  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_PAD   = 3'd5;

  // Register reset values.
  localparam logic [PHASE_W-1:0] PHASE_FIRST_RST  = 8'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND_RST = 8'd1;
  localparam logic [SIZE_W-1:0]  SIZE_RST         = 9'd256;
  localparam logic [PAD_W-1:0]   PAD_RST          = 7'd0;

  // Raw configuration register contents.
  typedef struct packed {
    logic [PHASE_W-1:0] phase_first;
    logic [PHASE_W-1:0] phase_second;
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
    logic [PAD_W-1:0]   border_pad;
  } cfg_regs_t;

endpackage

[hdl/vifc_if.sv]
// Channel interfaces for voxel input, count results and configuration writes.
interface vifc_in_if #(
  parameter int LABEL_BITS = vifc_pkg::LABEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LABEL_BITS-1:0] voxel_label;

  modport source (output valid, output voxel_label, input ready);
  modport sink (input valid, input voxel_label, output ready);
endinterface

interface vifc_out_if;
  logic                        valid;
  logic                        ready;
  logic [vifc_pkg::FACE_W-1:0] face_total;
  logic [vifc_pkg::CELL_W-1:0] cell_total;

  modport source (output valid, output face_total, output cell_total, input ready);
  modport sink (input valid, input face_total, input cell_total, output ready);
endinterface

interface vifc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vifc_pkg::CFG_IDX_W-1:0]  index;
  logic [vifc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/voxel_interface_face_counter.sv]
// Top level of the voxel interface face counter: raster tracking, neighbor stores, counting.
//
//  Channel  | Dir | Payload                   | Beat
//  ---------+-----+---------------------------+-------------------------------
//  in_ch    | in  | voxel_label               | one voxel, x fastest then y, z
//  out_ch   | out | face_total, cell_total    | one per finished volume
//  cfg_ch   | in  | index, data               | one register write
//
//  One voxel per cycle unless stalled; a result passes the counting and output registers.
//  The row store and plane store are RAMs read at accept and written as the counting stage
//  fires; a same-address write and read together are forwarded, so no interlock is needed.
//  Reset is synchronous and clears positions, counters and pipeline flags; stores stay unset.
//  Input stalls only when a finished volume waits in the output register while the next
//  volume's last voxel is also ready to leave the counting stage.
module voxel_interface_face_counter #(
  parameter int MAX_DIM    = vifc_pkg::MAX_DIM_DEF,
  parameter int LABEL_BITS = vifc_pkg::LABEL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vifc_in_if.sink    in_ch,
  vifc_out_if.source out_ch,
  vifc_cfg_if.sink   cfg_ch
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int PAW = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW  = ((CW > vifc_pkg::SIZE_W) ? CW : vifc_pkg::SIZE_W) + 2;
  localparam int FW  = vifc_pkg::FACE_W;
  localparam int LW  = vifc_pkg::CELL_W;

  // Clamp a size register to the range 1 .. MAX_DIM.
  function automatic logic [IW-1:0] eff_size(input logic [vifc_pkg::SIZE_W-1:0] s);
    logic [IW-1:0] sw;
    logic [IW-1:0] res;
    sw = IW'(s);
    if (sw == '0) begin
      res = IW'(1);
    end else if (sw > IW'(MAX_DIM)) begin
      res = IW'(MAX_DIM);
    end else begin
      res = sw;
    end
    return res;
  endfunction

  // Coordinate lies within the padded interior of an axis.
  function automatic logic in_interior(input logic [IW-1:0] p, input logic [IW-1:0] pad,
                                       input logic [IW-1:0] sz);
    return (p >= pad) && ((p + pad) < sz);
  endfunction

  // The two labels form the configured phase pair, in either order.
  function automatic logic is_pair(input logic [LABEL_BITS-1:0] a,
                                   input logic [LABEL_BITS-1:0] b,
                                   input logic [LABEL_BITS-1:0] pa,
                                   input logic [LABEL_BITS-1:0] pb);
    return ((a == pa) && (b == pb)) || ((a == pb) && (b == pa));
  endfunction

  vifc_pkg::cfg_regs_t cfg;

  // Configuration registers.
  vifc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (cfg)
  );

  logic [LABEL_BITS-1:0] phase_a;
  logic [LABEL_BITS-1:0] phase_b;
  logic [IW-1:0]         pad_w;
  logic [IW-1:0]         eff_x;
  logic [IW-1:0]         eff_y;
  logic [IW-1:0]         eff_z;

  // Derived settings.
  assign phase_a = LABEL_BITS'(cfg.phase_first);
  assign phase_b = LABEL_BITS'(cfg.phase_second);
  assign pad_w   = IW'(cfg.border_pad);
  assign eff_x   = eff_size(cfg.size_x);
  assign eff_y   = eff_size(cfg.size_y);
  assign eff_z   = eff_size(cfg.size_z);

  // Raster position and previous voxel.
  logic [CW-1:0]         pos_x_r;
  logic [CW-1:0]         pos_y_r;
  logic [CW-1:0]         pos_z_r;
  logic [LABEL_BITS-1:0] prev_voxel_r;

  // Counting stage registers.
  logic                  s1_valid_r;
  logic                  s1_cell_r;
  logic                  s1_fx_r;
  logic                  s1_fy_en_r;
  logic                  s1_fz_en_r;
  logic                  s1_last_r;
  logic [LABEL_BITS-1:0] s1_label_r;
  logic [CW-1:0]         s1_row_addr_r;
  logic [PAW-1:0]        s1_plane_addr_r;
  logic                  row_fwd_r;
  logic                  plane_fwd_r;
  logic [LABEL_BITS-1:0] fwd_label_r;

  // Accumulators and output register.
  logic [FW-1:0] face_acc_r;
  logic [FW-1:0] face_acc_nxt;
  logic [LW-1:0] cell_acc_r;
  logic [LW-1:0] cell_acc_nxt;
  logic          out_valid_r;
  logic [FW-1:0] out_face_r;
  logic [LW-1:0] out_cell_r;

  logic                  accept;
  logic                  stall;
  logic                  s1_fire;
  logic [LABEL_BITS-1:0] label;
  logic [IW-1:0]         x_w;
  logic [IW-1:0]         y_w;
  logic [IW-1:0]         z_w;
  logic                  cell0;
  logic                  fx0;
  logic                  fy_en0;
  logic                  fz_en0;
  logic                  last_x;
  logic                  last_y;
  logic                  last_z;
  logic [PAW-1:0]        plane_addr0;
  logic [LABEL_BITS-1:0] row_q;
  logic [LABEL_BITS-1:0] plane_q;
  logic [LABEL_BITS-1:0] row_nb;
  logic [LABEL_BITS-1:0] plane_nb;
  logic                  fy1;
  logic                  fz1;
  logic [1:0]            n_faces;
  logic [FW:0]           face_sum;
  logic [FW-1:0]         face_new;
  logic [LW-1:0]         cell_new;

  // Handshake: the counting stage holds only when its result cannot enter the output register.
  assign stall       = s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready;
  assign s1_fire     = s1_valid_r && !stall;
  assign in_ch.ready = !stall;
  assign accept      = in_ch.valid && !stall;
  assign label       = in_ch.voxel_label;

  // Position decode for the incoming voxel.
  assign x_w    = IW'(pos_x_r);
  assign y_w    = IW'(pos_y_r);
  assign z_w    = IW'(pos_z_r);
  assign cell0  = in_interior(x_w, pad_w, eff_x) && in_interior(y_w, pad_w, eff_y)
               && in_interior(z_w, pad_w, eff_z);
  assign fx0    = cell0 && (x_w > pad_w) && is_pair(prev_voxel_r, label, phase_a, phase_b);
  assign fy_en0 = cell0 && (y_w > pad_w);
  assign fz_en0 = cell0 && (z_w > pad_w);
  assign last_x = (x_w + IW'(1)) >= eff_x;
  assign last_y = (y_w + IW'(1)) >= eff_y;
  assign last_z = (z_w + IW'(1)) >= eff_z;
  assign plane_addr0 = PAW'(pos_y_r) * PAW'(MAX_DIM) + PAW'(pos_x_r);

  // Neighbor one row back.
  vifc_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (MAX_DIM)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_row_addr_r),
    .wdata (s1_label_r),
    .re    (accept),
    .raddr (pos_x_r),
    .rdata (row_q)
  );

  // Neighbor one plane back.
  vifc_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_plane_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_plane_addr_r),
    .wdata (s1_label_r),
    .re    (accept),
    .raddr (plane_addr0),
    .rdata (plane_q)
  );

  // Neighbor compare with forwarding of the write that coincided with the read.
  assign row_nb   = row_fwd_r ? fwd_label_r : row_q;
  assign plane_nb = plane_fwd_r ? fwd_label_r : plane_q;
  assign fy1      = s1_fy_en_r && is_pair(row_nb, s1_label_r, phase_a, phase_b);
  assign fz1      = s1_fz_en_r && is_pair(plane_nb, s1_label_r, phase_a, phase_b);
  assign n_faces  = {1'b0, s1_fx_r} + {1'b0, fy1} + {1'b0, fz1};

  // Saturating accumulate.
  assign face_sum = {1'b0, face_acc_r} + (FW + 1)'(n_faces);
  assign face_new = (face_sum > {1'b0, vifc_pkg::FACE_MAX}) ? vifc_pkg::FACE_MAX
                                                             : face_sum[FW-1:0];
  assign cell_new = (s1_cell_r && (cell_acc_r != vifc_pkg::CELL_MAX))
                  ? cell_acc_r + LW'(1) : cell_acc_r;

  always_comb begin
    face_acc_nxt = face_acc_r;
    cell_acc_nxt = cell_acc_r;
    if (s1_fire) begin
      face_acc_nxt = s1_last_r ? '0 : face_new;
      cell_acc_nxt = s1_last_r ? '0 : cell_new;
    end
  end

  // Raster position advance and the voxel history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      pos_z_r      <= '0;
      prev_voxel_r <= '0;
    end else if (accept) begin
      prev_voxel_r <= label;
      if (last_x) begin
        pos_x_r <= '0;
        if (last_y) begin
          pos_y_r <= '0;
          pos_z_r <= last_z ? '0 : pos_z_r + CW'(1);
        end else begin
          pos_y_r <= pos_y_r + CW'(1);
        end
      end else begin
        pos_x_r <= pos_x_r + CW'(1);
      end
    end
  end

  // Counting stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Counting stage payload and forwarding capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell_r       <= cell0;
      s1_fx_r         <= fx0;
      s1_fy_en_r      <= fy_en0;
      s1_fz_en_r      <= fz_en0;
      s1_last_r       <= last_x && last_y && last_z;
      s1_label_r      <= label;
      s1_row_addr_r   <= pos_x_r;
      s1_plane_addr_r <= plane_addr0;
      row_fwd_r       <= s1_fire && (s1_row_addr_r == pos_x_r);
      plane_fwd_r     <= s1_fire && (s1_plane_addr_r == plane_addr0);
      fwd_label_r     <= s1_label_r;
    end
  end

  // Accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_acc_r <= '0;
      cell_acc_r <= '0;
    end else begin
      face_acc_r <= face_acc_nxt;
      cell_acc_r <= cell_acc_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_face_r <= face_new;
      out_cell_r <= cell_new;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.face_total = out_face_r;
  assign out_ch.cell_total = out_cell_r;

  // Input back-pressure only comes from a finished volume blocked behind a waiting result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input stalled without a blocked result");

  // Closing a volume clears both accumulators.
  a_acc_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> ((face_acc_r == '0) && (cell_acc_r == '0)))
    else $error("accumulators not cleared after volume end");

  // A closed volume always lands in the output register.
  a_result_out : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_valid_r)
    else $error("volume result lost");

  // A stalled counting stage keeps its item and its plane store address.
  a_hold_item : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_plane_addr_r)))
    else $error("held item changed in counting stage");

endmodule

[hdl/vifc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module vifc_ram #(
  parameter int WIDTH = vifc_pkg::LABEL_BITS_DEF,
  parameter int DEPTH = vifc_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port; a read at a written address sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[hdl/vifc_cfg.sv]
// Configuration register file: decodes write beats and holds the raw settings.
module vifc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  vifc_cfg_if.sink            cfg_ch,
  output vifc_pkg::cfg_regs_t regs
);

  vifc_pkg::cfg_regs_t regs_r;
  vifc_pkg::cfg_regs_t regs_nxt;
  logic                wr_en;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign regs         = regs_r;

  // Register decode; unknown indexes are ignored.
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (cfg_ch.index)
        vifc_pkg::REG_PHASE_FIRST: begin
          regs_nxt.phase_first = cfg_ch.data[vifc_pkg::PHASE_W-1:0];
        end
        vifc_pkg::REG_PHASE_SECOND: begin
          regs_nxt.phase_second = cfg_ch.data[vifc_pkg::PHASE_W-1:0];
        end
        vifc_pkg::REG_SIZE_X: begin
          regs_nxt.size_x = cfg_ch.data[vifc_pkg::SIZE_W-1:0];
        end
        vifc_pkg::REG_SIZE_Y: begin
          regs_nxt.size_y = cfg_ch.data[vifc_pkg::SIZE_W-1:0];
        end
        vifc_pkg::REG_SIZE_Z: begin
          regs_nxt.size_z = cfg_ch.data[vifc_pkg::SIZE_W-1:0];
        end
        vifc_pkg::REG_BORDER_PAD: begin
          regs_nxt.border_pad = cfg_ch.data[vifc_pkg::PAD_W-1:0];
        end
        default: begin
          regs_nxt = regs_r;
        end
      endcase
    end
  end

  // Register storage with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.phase_first  <= vifc_pkg::PHASE_FIRST_RST;
      regs_r.phase_second <= vifc_pkg::PHASE_SECOND_RST;
      regs_r.size_x       <= vifc_pkg::SIZE_RST;
      regs_r.size_y       <= vifc_pkg::SIZE_RST;
      regs_r.size_z       <= vifc_pkg::SIZE_RST;
      regs_r.border_pad   <= vifc_pkg::PAD_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule
